FILE: src/gld_pkg.sv
// Shared constants, types and helpers for the GIF LZW decoder.
// No dependencies.
package gld_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int STACK_DEPTH   = 4096;
  localparam int MAX_CODE_BITS = 12;

  localparam int TBL_AW = $clog2(TABLE_ENTRIES);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int NUM_W  = 13;
  localparam int ENT_W  = MAX_CODE_BITS + 8;

  localparam logic [NUM_W-1:0] TBL_LIM   = NUM_W'(TABLE_ENTRIES);
  localparam logic [NUM_W-1:0] WIDTH_MAX = NUM_W'(1 << MAX_CODE_BITS);
  localparam logic [LVL_W-1:0] STK_LIM   = LVL_W'(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_PIXEL   = 2'd0,
    ST_NEED    = 2'd1,
    ST_END     = 2'd2,
    ST_CORRUPT = 2'd3
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } opcode_t;

  localparam logic [3:0] SIZE_RESET = 4'd8;

  function automatic logic [3:0] size_sat(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < 4'd2) r = 4'd2;
    if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

FILE: src/gld_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gif_lzw_decoder.sv
// GIF LZW decoder top level: bit buffer, code parser, chain walker, output stack.
// Depends on gld_pkg and gld_ram.
//
// Every item is accepted in the idle state, and each result is registered.
// A push, and a pull that answers from the end or corrupt flag, are answered
// straight from the accept. A pull that pops a waiting pixel goes through the
// accept, then the stack RAM read. A pull that parses codes goes through the
// accept, then the examination of each code (clear codes included, and the check
// that finds too few bits for a whole code), then a walk over each non-root
// link of the string, as the chain walker follows the prefix table at one RAM
// read per cycle. No clearing pass is needed after reset or restart: only
// table entries written since the last clear are ever read.
module gif_lzw_decoder
  import gld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pixel,
  output logic [1:0] status,
  output logic       byte_taken,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] initial_code_size
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_DEC  = 4'b0100,
    S_WALK = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [3:0]              size_q;
  logic [3:0]              code_w, code_w_next;
  logic [NUM_W-1:0]        nf, nf_next;
  logic [NUM_W-1:0]        wl, wl_next;
  logic [7:0]              first_v, first_v_next;
  logic [MAX_CODE_BITS-1:0] prev, prev_next;
  logic [MAX_CODE_BITS-1:0] incode, incode_next;
  logic                    awaiting, awaiting_next;
  logic                    ended, ended_next;
  logic                    broken, broken_next;
  logic [31:0]             bitbuf, bitbuf_next;
  logic [5:0]              bitcnt, bitcnt_next;
  logic [LVL_W-1:0]        level, level_next;
  logic                    out_valid_next, byte_taken_next;
  logic [7:0]              pixel_next;
  logic [1:0]              status_next;

  logic              t_we;
  logic [TBL_AW-1:0] t_waddr, t_raddr;
  logic [ENT_W-1:0]  t_wdata, t_rdata;
  logic              s_we;
  logic [STK_AW-1:0] s_waddr, s_raddr;
  logic [7:0]        s_wdata, s_rdata;

  logic [NUM_W-1:0]         clr;
  logic [NUM_W-1:0]         code;
  logic [MAX_CODE_BITS-1:0] cur;
  logic [MAX_CODE_BITS-1:0] t_prefix;
  logic [NUM_W-1:0]         nf_inc;
  logic                     accept, fin, bad, issue;
  logic [7:0]               root;

  gld_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign clr       = NUM_W'(1) << size_q;
  assign t_prefix  = t_rdata[ENT_W-1:8];
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign code      = NUM_W'(bitbuf & ((32'd1 << code_w) - 32'd1));
  assign nf_inc    = nf + NUM_W'(1);

  always_comb begin
    state_next      = state;
    code_w_next     = code_w;
    nf_next         = nf;
    wl_next         = wl;
    first_v_next    = first_v;
    prev_next       = prev;
    incode_next     = incode;
    awaiting_next   = awaiting;
    ended_next      = ended;
    broken_next     = broken;
    bitbuf_next     = bitbuf;
    bitcnt_next     = bitcnt;
    level_next      = level;
    out_valid_next  = out_valid && out_stall;
    pixel_next      = pixel;
    status_next     = status;
    byte_taken_next = byte_taken;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    fin   = 1'b0;
    bad   = 1'b0;
    issue = 1'b0;
    root  = '0;
    cur   = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_PUSH) begin
            out_valid_next  = 1'b1;
            pixel_next      = '0;
            status_next     = ST_PIXEL;
            byte_taken_next = 1'b0;
            if (bitcnt <= 6'd24) begin
              bitbuf_next     = bitbuf | (32'(data_byte) << bitcnt);
              bitcnt_next     = bitcnt + 6'd8;
              byte_taken_next = 1'b1;
            end
          end else if (broken) begin
            out_valid_next  = 1'b1;
            pixel_next      = '0;
            status_next     = ST_CORRUPT;
            byte_taken_next = 1'b0;
          end else if (level != '0) begin
            s_raddr    = STK_AW'(level - LVL_W'(1));
            level_next = level - LVL_W'(1);
            state_next = S_POP;
          end else if (ended) begin
            out_valid_next  = 1'b1;
            pixel_next      = '0;
            status_next     = ST_END;
            byte_taken_next = 1'b0;
          end else begin
            state_next = S_DEC;
          end
        end
      end
      S_POP: begin
        out_valid_next  = 1'b1;
        pixel_next      = s_rdata;
        status_next     = ST_PIXEL;
        byte_taken_next = 1'b0;
        state_next      = S_IDLE;
      end
      S_DEC: begin
        if (bitcnt < 6'(code_w)) begin
          out_valid_next  = 1'b1;
          pixel_next      = '0;
          status_next     = ST_NEED;
          byte_taken_next = 1'b0;
          state_next      = S_IDLE;
        end else begin
          bitbuf_next = bitbuf >> code_w;
          bitcnt_next = bitcnt - 6'(code_w);
          if (code == clr) begin
            code_w_next   = size_q + 4'd1;
            nf_next       = clr + NUM_W'(2);
            wl_next       = clr << 1;
            awaiting_next = 1'b1;
          end else if (code == clr + NUM_W'(1)) begin
            ended_next      = 1'b1;
            out_valid_next  = 1'b1;
            pixel_next      = '0;
            status_next     = ST_END;
            byte_taken_next = 1'b0;
            state_next      = S_IDLE;
          end else if (awaiting) begin
            if (code > clr) begin
              bad = 1'b1;
            end else begin
              awaiting_next   = 1'b0;
              first_v_next    = code[7:0];
              prev_next       = MAX_CODE_BITS'(code);
              out_valid_next  = 1'b1;
              pixel_next      = code[7:0];
              status_next     = ST_PIXEL;
              byte_taken_next = 1'b0;
              state_next      = S_IDLE;
            end
          end else if (code > nf) begin
            bad = 1'b1;
          end else begin
            incode_next = MAX_CODE_BITS'(code);
            cur         = MAX_CODE_BITS'(code);
            if (code == nf) begin
              s_we       = 1'b1;
              s_waddr    = STK_AW'(level);
              s_wdata    = first_v;
              level_next = level + LVL_W'(1);
              cur        = prev;
            end
            if (NUM_W'(cur) < clr) begin
              fin  = 1'b1;
              root = cur[7:0];
            end else begin
              issue = 1'b1;
            end
          end
        end
      end
      S_WALK: begin
        if (level >= STK_LIM) begin
          bad = 1'b1;
        end else begin
          s_we       = 1'b1;
          s_waddr    = STK_AW'(level);
          s_wdata    = t_rdata[7:0];
          level_next = level + LVL_W'(1);
          cur        = t_prefix;
          if (NUM_W'(cur) < clr) begin
            fin  = 1'b1;
            root = cur[7:0];
          end else begin
            issue = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (issue) begin
      if (NUM_W'(cur) >= TBL_LIM) begin
        bad = 1'b1;
      end else begin
        t_raddr    = TBL_AW'(cur);
        state_next = S_WALK;
      end
    end

    if (fin) begin
      if (level_next >= STK_LIM) begin
        bad = 1'b1;
      end else begin
        first_v_next = root;
        if (nf < TBL_LIM) begin
          t_we    = 1'b1;
          t_waddr = TBL_AW'(nf);
          t_wdata = {prev, root};
          nf_next = nf_inc;
          if (nf_inc >= wl && wl < WIDTH_MAX) begin
            wl_next     = wl << 1;
            code_w_next = code_w + 4'd1;
          end
        end
        prev_next       = (state == S_DEC) ? MAX_CODE_BITS'(code) : incode;
        out_valid_next  = 1'b1;
        pixel_next      = root;
        status_next     = ST_PIXEL;
        byte_taken_next = 1'b0;
        state_next      = S_IDLE;
      end
    end

    if (bad) begin
      s_we            = 1'b0;
      t_we            = 1'b0;
      broken_next     = 1'b1;
      level_next      = '0;
      out_valid_next  = 1'b1;
      pixel_next      = '0;
      status_next     = ST_CORRUPT;
      byte_taken_next = 1'b0;
      state_next      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready)) begin
      logic [3:0] sz;
      sz = rst ? SIZE_RESET : size_sat(initial_code_size);
      size_q    <= sz;
      code_w    <= sz + 4'd1;
      nf        <= (NUM_W'(1) << sz) + NUM_W'(2);
      wl        <= NUM_W'(1) << (sz + 4'd1);
      first_v   <= '0;
      prev      <= '0;
      awaiting  <= 1'b1;
      ended     <= 1'b0;
      broken    <= 1'b0;
      bitbuf    <= '0;
      bitcnt    <= '0;
      level     <= '0;
      state     <= S_IDLE;
      out_valid <= rst ? 1'b0 : out_valid_next;
    end else begin
      state     <= state_next;
      code_w    <= code_w_next;
      nf        <= nf_next;
      wl        <= wl_next;
      first_v   <= first_v_next;
      prev      <= prev_next;
      awaiting  <= awaiting_next;
      ended     <= ended_next;
      broken    <= broken_next;
      bitbuf    <= bitbuf_next;
      bitcnt    <= bitcnt_next;
      level     <= level_next;
      out_valid <= out_valid_next;
    end
    incode     <= incode_next;
    pixel      <= pixel_next;
    status     <= status_next;
    byte_taken <= byte_taken_next;
  end

endmodule

FILE: src/gld_checker.sv
// Port-level checks for the GIF LZW decoder, bound to the top level.
// Depends on gld_pkg.
module gld_checker
  import gld_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel,
  input logic [1:0] status,
  input logic       byte_taken,
  input logic       cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel) && $stable(status))
    else $error("stalled result changed");

  a_zero_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PIXEL |-> pixel == 8'd0)
    else $error("pixel not zero on status");

  a_taken_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_taken |-> status == ST_PIXEL)
    else $error("byte taken with non-pixel status");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall || (out_valid && out_stall))
    else $error("config ready while busy");

endmodule

bind gif_lzw_decoder gld_checker u_gld_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .pixel(pixel), .status(status),
  .byte_taken(byte_taken), .cfg_ready(cfg_ready)
);
